>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/dda_pkg.sv
package dda_pkg;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int ACC_BITS   = COORD_BITS + FRAC_BITS + 1;
  localparam int STEP_BITS  = FRAC_BITS + 2;
  localparam int QUOT_BITS  = FRAC_BITS + 1;

  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS = Q_PTR_BITS + 1;

  localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 2);

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  typedef enum logic {
    BK_RUN,
    BK_DIV
  } back_state_t;

  typedef struct packed {
    logic                  is_step;
    logic                  y_major;
    logic [COORD_BITS-1:0] maj0;
    logic [COORD_BITS-1:0] maj1;
    logic [COORD_BITS-1:0] min0;
    logic                  dmin_neg;
    logic [COORD_BITS-1:0] dmin_mag;
    logic [COORD_BITS-1:0] dmaj;
  } cmd_t;

  typedef struct packed {
    logic                  start;
    logic [COORD_BITS-1:0] num;
    logic [COORD_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [QUOT_BITS-1:0] quot;
  } div_rsp_t;

endpackage

>>> rtl/core/dda_front.sv
`include "assert_macros.svh"

module dda_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [dda_pkg::COORD_BITS-1:0] x_start,
  input  logic [dda_pkg::COORD_BITS-1:0] y_start,
  input  logic [dda_pkg::COORD_BITS-1:0] x_end,
  input  logic [dda_pkg::COORD_BITS-1:0] y_end,
  output logic                           q_valid,
  output dda_pkg::cmd_t                  q_head,
  input  logic                           q_pop
);

  dda_pkg::cmd_t                   q_mem [dda_pkg::Q_DEPTH];
  logic [dda_pkg::Q_PTR_BITS-1:0]  wr_ptr;
  logic [dda_pkg::Q_PTR_BITS-1:0]  rd_ptr;
  logic [dda_pkg::Q_CNT_BITS-1:0]  count;
  logic                            push;
  dda_pkg::cmd_t                   cmd;

  logic signed [dda_pkg::COORD_BITS:0] dx;
  logic signed [dda_pkg::COORD_BITS:0] dy;
  logic signed [dda_pkg::COORD_BITS:0] dmin;
  logic [dda_pkg::COORD_BITS-1:0]      adx;
  logic [dda_pkg::COORD_BITS-1:0]      ady;
  logic                                ymaj;
  logic [dda_pkg::COORD_BITS-1:0]      maj_a;
  logic [dda_pkg::COORD_BITS-1:0]      maj_b;
  logic [dda_pkg::COORD_BITS-1:0]      min_a;
  logic [dda_pkg::COORD_BITS-1:0]      min_b;
  logic [dda_pkg::COORD_BITS-1:0]      maj0;
  logic [dda_pkg::COORD_BITS-1:0]      maj1;
  logic [dda_pkg::COORD_BITS-1:0]      min0;
  logic [dda_pkg::COORD_BITS-1:0]      min1;

  // classify: pick the major axis and order the endpoints
  always_comb begin
    dx    = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    dy    = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx   = dx[dda_pkg::COORD_BITS] ? dda_pkg::COORD_BITS'(-dx) : dda_pkg::COORD_BITS'(dx);
    ady   = dy[dda_pkg::COORD_BITS] ? dda_pkg::COORD_BITS'(-dy) : dda_pkg::COORD_BITS'(dy);
    ymaj  = adx < ady;
    maj_a = ymaj ? y_start : x_start;
    maj_b = ymaj ? y_end   : x_end;
    min_a = ymaj ? x_start : y_start;
    min_b = ymaj ? x_end   : y_end;
    if (maj_a > maj_b) begin
      maj0 = maj_b;
      maj1 = maj_a;
      min0 = min_b;
      min1 = min_a;
    end else begin
      maj0 = maj_a;
      maj1 = maj_b;
      min0 = min_a;
      min1 = min_b;
    end
    dmin = $signed({1'b0, min1}) - $signed({1'b0, min0});
    cmd.is_step  = (req_type == dda_pkg::REQ_STEP);
    cmd.y_major  = ymaj;
    cmd.maj0     = maj0;
    cmd.maj1     = maj1;
    cmd.min0     = min0;
    cmd.dmin_neg = dmin[dda_pkg::COORD_BITS];
    cmd.dmin_mag = dmin[dda_pkg::COORD_BITS] ? dda_pkg::COORD_BITS'(-dmin)
                                             : dda_pkg::COORD_BITS'(dmin);
    cmd.dmaj     = maj1 - maj0;
  end

  assign in_stall = (count == dda_pkg::Q_CNT_BITS'(dda_pkg::Q_DEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_head   = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPL(a_pop_needs_entry, q_pop, q_valid, "pop from empty queue")
  `ASSERT_IMPL(a_count_bound, 1'b1, count <= dda_pkg::Q_CNT_BITS'(dda_pkg::Q_DEPTH),
               "queue overfilled")

endmodule

>>> rtl/core/dda_div.sv
`include "assert_macros.svh"

module dda_div (
  input  logic              clk,
  input  logic              rst,
  input  dda_pkg::div_req_t req,
  output dda_pkg::div_rsp_t rsp
);

  logic [dda_pkg::COORD_BITS:0]     rem;
  logic [dda_pkg::COORD_BITS-1:0]   den;
  logic [dda_pkg::QUOT_BITS-1:0]    quot;
  logic [dda_pkg::DIV_CNT_BITS-1:0] cnt;
  logic                             busy;
  logic                             done;
  logic                             qbit;
  logic [dda_pkg::COORD_BITS:0]     rem_sub;

  // restoring division of num * 2^FRAC_BITS by den, one quotient bit a cycle
  always_comb begin
    qbit    = (den != '0) && (rem >= {1'b0, den});
    rem_sub = qbit ? (rem - {1'b0, den}) : rem;
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= {1'b0, req.num};
      den  <= req.den;
      quot <= '0;
    end else if (busy) begin
      rem  <= {rem_sub[dda_pkg::COORD_BITS-1:0], 1'b0};
      quot <= {quot[dda_pkg::QUOT_BITS-2:0], qbit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == dda_pkg::DIV_CNT_BITS'(dda_pkg::FRAC_BITS)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.quot = quot;

  `ASSERT_NEXT(a_start_busy, req.start, busy, "divider not busy after start")
  `ASSERT_IMPL(a_done_idle, done, !busy, "divider done while busy")

endmodule

>>> rtl/core/dda_back.sv
`include "assert_macros.svh"

module dda_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  dda_pkg::cmd_t                  q_head,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_y,
  output logic                           pixel_valid,
  output logic                           last_pixel
);

  dda_pkg::back_state_t state;
  dda_pkg::back_state_t state_next;
  dda_pkg::div_req_t    div_req;
  dda_pkg::div_rsp_t    div_rsp;

  logic                                  active;
  logic                                  y_major;
  logic [dda_pkg::COORD_BITS-1:0]        major_pos;
  logic [dda_pkg::COORD_BITS-1:0]        major_stop;
  logic signed [dda_pkg::ACC_BITS-1:0]   minor_accum;
  logic signed [dda_pkg::STEP_BITS-1:0]  minor_step;
  logic                                  step_neg;

  logic                                  out_free;
  logic                                  load_line;
  logic                                  emit;
  logic                                  last;
  logic [dda_pkg::ACC_BITS-1:0]          rounded;
  logic [dda_pkg::COORD_BITS-1:0]        minor;
  logic signed [dda_pkg::STEP_BITS-1:0]  quot_ext;

  dda_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dda_pkg::BK_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    q_pop       = 1'b0;
    load_line   = 1'b0;
    emit        = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = q_head.dmin_mag;
    div_req.den   = q_head.dmaj;
    case (state)
      dda_pkg::BK_RUN: begin
        if (q_valid) begin
          if (!q_head.is_step) begin
            q_pop         = 1'b1;
            load_line     = 1'b1;
            div_req.start = 1'b1;
            state_next    = dda_pkg::BK_DIV;
          end else if (out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
          end
        end
      end
      dda_pkg::BK_DIV: begin
        if (div_rsp.done) begin
          state_next = dda_pkg::BK_RUN;
        end
      end
      default: begin
        state_next = dda_pkg::BK_RUN;
      end
    endcase
  end

  always_comb begin
    rounded  = minor_accum + (dda_pkg::ACC_BITS'(1) << (dda_pkg::FRAC_BITS - 1));
    minor    = rounded[dda_pkg::FRAC_BITS +: dda_pkg::COORD_BITS];
    last     = major_pos >= major_stop;
    quot_ext = $signed({1'b0, div_rsp.quot});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      y_major     <= 1'b0;
      major_pos   <= '0;
      major_stop  <= '0;
      minor_accum <= '0;
      minor_step  <= '0;
      step_neg    <= 1'b0;
    end else begin
      if (load_line) begin
        active      <= 1'b1;
        y_major     <= q_head.y_major;
        major_pos   <= q_head.maj0;
        major_stop  <= q_head.maj1;
        minor_accum <= $signed({1'b0, q_head.min0, dda_pkg::FRAC_BITS'(0)});
        minor_step  <= '0;
        step_neg    <= q_head.dmin_neg;
      end else if (state == dda_pkg::BK_DIV && div_rsp.done) begin
        minor_step <= step_neg ? -quot_ext : quot_ext;
      end else if (emit && active) begin
        if (last) begin
          active <= 1'b0;
        end else begin
          major_pos   <= major_pos + 1'b1;
          minor_accum <= minor_accum + dda_pkg::ACC_BITS'(minor_step);
        end
      end
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (!active) begin
        pixel_x     <= '0;
        pixel_y     <= '0;
        pixel_valid <= 1'b0;
        last_pixel  <= 1'b0;
      end else begin
        pixel_x     <= y_major ? minor : major_pos;
        pixel_y     <= y_major ? major_pos : minor;
        pixel_valid <= 1'b1;
        last_pixel  <= last;
      end
    end
  end

  `ASSERT_IMPL(a_no_emit_in_div, state == dda_pkg::BK_DIV, !emit && !q_pop,
               "request taken while dividing")
  `ASSERT_NEXT(a_last_clears, emit && active && last, !active,
               "line still active after last pixel")

endmodule

>>> rtl/core/dda_line_rasterizer.sv
// DDA line rasterizer.
// Input channel (in_valid / in_stall): req_type 0 is a start request carrying
// x_start, y_start, x_end, y_end; req_type 1 is a step request. A start
// request gives no result and drops any line in progress. Each step request
// gives one result on the output channel (out_valid / out_stall): the next
// pixel of the line with pixel_valid 1 and last_pixel on the final one, or
// pixel_valid 0 with zero fields when no line is active.
// Requests enter a four-entry queue and are carried out in order by the back
// end. A step request passes through its queue entry and the output register
// before it is delivered, and steps run at one per cycle while the receiver
// does not stall and no start request is in the divider. A start request
// holds the back end in BK_DIV while the iterative divider works out the
// slope one quotient bit per cycle; steps queued behind it wait, and the
// queue keeps accepting. When the receiver stalls, the result holds in the
// output register and the queue absorbs up to four more requests before
// in_stall rises. Reset (rst, synchronous) empties the queue, clears
// out_valid and leaves no line active.

module dda_line_rasterizer (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [dda_pkg::COORD_BITS-1:0] x_start,
  input  logic [dda_pkg::COORD_BITS-1:0] y_start,
  input  logic [dda_pkg::COORD_BITS-1:0] x_end,
  input  logic [dda_pkg::COORD_BITS-1:0] y_end,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_x,
  output logic [dda_pkg::COORD_BITS-1:0] pixel_y,
  output logic                           pixel_valid,
  output logic                           last_pixel
);

  logic          q_valid;
  logic          q_pop;
  dda_pkg::cmd_t q_head;

  dda_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .x_start  (x_start),
    .y_start  (y_start),
    .x_end    (x_end),
    .y_end    (y_end),
    .q_valid  (q_valid),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  dda_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel)
  );

endmodule

>>> tb/dda_line_rasterizer_tb.sv
`timescale 1ns / 100ps

module dda_line_rasterizer_tb;

  localparam int COORD_MAX = (1 << dda_pkg::COORD_BITS) - 1;
  localparam int ITEMS = 1450;

  typedef logic [dda_pkg::COORD_BITS-1:0] coord_t;

  typedef struct {
    logic   kind;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
  } request_t;

  typedef struct {
    coord_t px;
    coord_t py;
    logic   vld;
    logic   last;
  } pixel_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   in_valid = 1'b0;
  logic   in_stall;
  logic   req_type = dda_pkg::REQ_STEP;
  coord_t x_start = '0;
  coord_t y_start = '0;
  coord_t x_end = '0;
  coord_t y_end = '0;
  logic   out_valid;
  logic   out_stall = 1'b0;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   pixel_valid;
  logic   last_pixel;

  request_t pending_q[$];
  pixel_t   pixel_q[$];
  request_t cur;
  pixel_t   want;

  logic   line_on = 1'b0;
  logic   steep = 1'b0;
  coord_t maj_pos = '0;
  coord_t maj_stop = '0;
  longint minor_acc = 0;
  longint minor_inc = 0;

  int   n_accepted = 0;
  int   n_results = 0;
  int   n_errors = 0;
  int   n_lines = 0;
  int   n_drawn = 0;
  int   n_ends = 0;
  int   n_empty = 0;
  int   hold_cnt = 0;
  logic hold_off = 1'b0;
  logic hold_done = 1'b0;

  wire quiet = n_accepted >= 500 && n_accepted < 800;

  dda_line_rasterizer u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .x_start     (x_start),
    .y_start     (y_start),
    .x_end       (x_end),
    .y_end       (y_end),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_valid (pixel_valid),
    .last_pixel  (last_pixel)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic rasterize(input request_t r);
    int     dx;
    int     dy;
    int     maj0;
    int     maj1;
    int     min0;
    int     min1;
    int     t;
    coord_t mn;
    pixel_t p;
    if (r.kind == dda_pkg::REQ_START) begin
      dx = int'(r.xe) - int'(r.xs);
      dy = int'(r.ye) - int'(r.ys);
      steep = (dx < 0 ? -dx : dx) < (dy < 0 ? -dy : dy);
      if (steep) begin
        maj0 = r.ys; maj1 = r.ye; min0 = r.xs; min1 = r.xe;
      end else begin
        maj0 = r.xs; maj1 = r.xe; min0 = r.ys; min1 = r.ye;
      end
      if (maj0 > maj1) begin
        t = maj0; maj0 = maj1; maj1 = t;
        t = min0; min0 = min1; min1 = t;
      end
      if (maj1 == maj0)
        minor_inc = 0;
      else
        minor_inc = (longint'(min1 - min0) * (longint'(1) << dda_pkg::FRAC_BITS)) /
                    longint'(maj1 - maj0);
      maj_pos = coord_t'(maj0);
      maj_stop = coord_t'(maj1);
      minor_acc = longint'(min0) << dda_pkg::FRAC_BITS;
      line_on = 1'b1;
      n_lines++;
    end else begin
      p = '{px: '0, py: '0, vld: 1'b0, last: 1'b0};
      if (line_on) begin
        mn = coord_t'((minor_acc + (longint'(1) << (dda_pkg::FRAC_BITS - 1)))
                      >>> dda_pkg::FRAC_BITS);
        p.px = steep ? mn : maj_pos;
        p.py = steep ? maj_pos : mn;
        p.vld = 1'b1;
        p.last = maj_pos >= maj_stop;
        if (p.last) begin
          line_on = 1'b0;
          n_ends++;
        end else begin
          maj_pos = maj_pos + 1'b1;
          minor_acc += minor_inc;
        end
        n_drawn++;
      end else begin
        n_empty++;
      end
      pixel_q.push_back(p);
    end
  endtask

  task automatic queue_start(input int x0, input int y0, input int x1, input int y1);
    request_t r;
    r.kind = dda_pkg::REQ_START;
    r.xs = coord_t'(x0);
    r.ys = coord_t'(y0);
    r.xe = coord_t'(x1);
    r.ye = coord_t'(y1);
    pending_q.push_back(r);
  endtask

  task automatic queue_steps(input int n);
    request_t r;
    repeat (n) begin
      r.kind = dda_pkg::REQ_STEP;
      r.xs = coord_t'($urandom);
      r.ys = coord_t'($urandom);
      r.xe = coord_t'($urandom);
      r.ye = coord_t'($urandom);
      pending_q.push_back(r);
    end
  endtask

  function automatic int pick_coord();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15)
      return $urandom_range(0, 20);
    if (r < 30)
      return COORD_MAX - int'($urandom_range(0, 20));
    return $urandom_range(0, COORD_MAX);
  endfunction

  function automatic int clamp(input int v);
    return v < 0 ? 0 : (v > COORD_MAX ? COORD_MAX : v);
  endfunction

  task automatic check_field(input string name, input coord_t exp_v, input coord_t got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      n_errors++;
    end
  endtask

  // driver: predict on acceptance, then offer the next request or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        rasterize(cur);
        n_accepted <= n_accepted + 1;
      end
      if (pending_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 37)) begin
        cur = pending_q.pop_front();
        req_type <= cur.kind;
        x_start <= cur.xs;
        y_start <= cur.ys;
        x_end <= cur.xe;
        y_end <= cur.ye;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results <= n_results + 1;
        if (pixel_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got x=%0d y=%0d valid=%0b last=%0b",
                   $time, pixel_x, pixel_y, pixel_valid, last_pixel);
          n_errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", want.px, pixel_x);
          check_field("pixel_y", want.py, pixel_y);
          check_field("pixel_valid", coord_t'(want.vld), coord_t'(pixel_valid));
          check_field("last_pixel", coord_t'(want.last), coord_t'(last_pixel));
        end
      end
      out_stall <= hold_off || (!quiet && $urandom_range(0, 99) < 37);
    end
  end

  // hold off the receiver once for a long stretch so the input backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_off <= 1'b0;
    end else if (!hold_done && n_results >= 250) begin
      hold_cnt <= hold_cnt + 1;
      hold_off <= hold_cnt < 80;
      if (hold_cnt == 80)
        hold_done <= 1'b1;
    end
  end

  initial begin
    int kind;
    int x0;
    int y0;
    int x1;
    int y1;
    int span;
    int nsteps;

    queue_steps(1);
    queue_start(5, 7, 5, 7);
    queue_steps(2);
    queue_start(COORD_MAX, 0, 0, COORD_MAX);
    queue_steps(3);
    queue_start(0, 0, 1, COORD_MAX);
    queue_steps(2);
    queue_start(COORD_MAX, COORD_MAX, COORD_MAX - 1, 0);
    queue_steps(2);
    queue_start(0, COORD_MAX, COORD_MAX, COORD_MAX - 1);
    queue_steps(2);
    queue_start(COORD_MAX - 2, 2, COORD_MAX, 3);
    queue_steps(4);

    while (pending_q.size() < ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        if ($urandom_range(0, 1))
          queue_start($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
        else
          queue_steps($urandom_range(1, 3));
      end else begin
        x0 = pick_coord();
        y0 = pick_coord();
        if (kind < 80) begin
          x1 = clamp(x0 + int'($urandom_range(0, 48)) - 24);
          y1 = clamp(y0 + int'($urandom_range(0, 48)) - 24);
          span = x1 > x0 ? x1 - x0 : x0 - x1;
          if ((y1 > y0 ? y1 - y0 : y0 - y1) > span)
            span = y1 > y0 ? y1 - y0 : y0 - y1;
          if ($urandom_range(0, 4) == 0)
            nsteps = $urandom_range(0, span);
          else
            nsteps = span + 1 + int'($urandom_range(0, 1));
        end else begin
          x1 = pick_coord();
          y1 = pick_coord();
          nsteps = $urandom_range(1, 30);
        end
        queue_start(x0, y0, x1, y1);
        queue_steps(nsteps);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending_q.size() != 0 || in_valid)
      @(posedge clk);
    while (pixel_q.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Ran %0d requests: %0d lines started, %0d pixels drawn, %0d line ends",
             n_accepted, n_lines, n_drawn, n_ends);
    $display("%0d steps with no line active, one long receiver hold-off, %0d mismatches",
             n_empty, n_errors);
    if (n_errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #6000000;
    $display("Timed out with %0d results outstanding", pixel_q.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
